[design/rwhp_pkg.sv]
`default_nettype none
package rwhp_pkg;

  localparam int POS_WIDTH_DEF = 40;
  localparam int CFG_W = 40;
  localparam int FB_W = 20;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SMALL      = 4'd1;
  localparam logic [3:0] ST_NOTRIFF    = 4'd2;
  localparam logic [3:0] ST_NOTWAVE    = 4'd3;
  localparam logic [3:0] ST_FMTCORRUPT = 4'd4;
  localparam logic [3:0] ST_EXTSMALL   = 4'd5;
  localparam logic [3:0] ST_NOFMT      = 4'd6;
  localparam logic [3:0] ST_NODATA     = 4'd7;
  localparam logic [3:0] ST_ENCODING   = 4'd8;
  localparam logic [3:0] ST_FLOATBITS  = 4'd9;
  localparam logic [3:0] ST_PCMBITS    = 4'd10;
  localparam logic [3:0] ST_CHANNELS   = 4'd11;
  localparam logic [3:0] ST_RATE       = 4'd12;
  localparam logic [3:0] ST_HEADER     = 4'd13;
  localparam logic [3:0] ST_TOOLARGE   = 4'd14;

  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_RF64 = 32'h3436_4652;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_DS64    = 32'h3436_7364;
  localparam logic [31:0] ID_FMT     = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA    = 32'h6174_6164;
  localparam logic [31:0] SIZE_ESC   = 32'hFFFF_FFFF;
  localparam logic [15:0] TAG_EXT    = 16'hFFFE;
  localparam logic [15:0] TAG_PCM    = 16'd1;
  localparam logic [15:0] TAG_FLOAT  = 16'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FMT  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_DS64 = 2'd3;

  localparam logic [1:0] REG_MAX_CH   = 2'd0;
  localparam logic [1:0] REG_MIN_RATE = 2'd1;
  localparam logic [1:0] REG_MAX_RATE = 2'd2;
  localparam logic [1:0] REG_LIMIT    = 2'd3;

  localparam logic [15:0] MAX_CH_RST   = 16'd64;
  localparam logic [31:0] MIN_RATE_RST = 32'd1;
  localparam logic [31:0] MAX_RATE_RST = 32'd768000;
  localparam logic [39:0] LIMIT_RST    = 40'd2000000000;

  typedef struct packed {
    logic byte_en;
    logic check_en;
    logic div_start;
    logic mul_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic fin_ok;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

[design/rwhp_if.sv]
`default_nettype none
interface rwhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface rwhp_out_if #(parameter int PW = 40);
  logic          valid;
  logic          ready;
  logic [3:0]    status;
  logic          is_float;
  logic          is_rf64;
  logic [15:0]   channel_count;
  logic [31:0]   sample_rate;
  logic [15:0]   bits_per_sample;
  logic [PW-1:0] data_offset;
  logic [PW-1:0] data_size;
  logic [PW-1:0] frame_count;
  modport source (output valid, output status, output is_float, output is_rf64,
                  output channel_count, output sample_rate, output bits_per_sample,
                  output data_offset, output data_size, output frame_count,
                  input ready);
  modport sink (input valid, input status, input is_float, input is_rf64,
                input channel_count, input sample_rate, input bits_per_sample,
                input data_offset, input data_size, input frame_count,
                output ready);
endinterface
`default_nettype wire

[design/rwhp_div.sv]
`default_nettype none
module rwhp_div import rwhp_pkg::*; #(
  parameter int PW = POS_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [PW-1:0]   dividend,
  input  wire logic [FB_W-1:0] divisor,
  output logic      [PW-1:0]   quotient,
  output logic                 done
);
  localparam int CW = $clog2(PW + 1);

  logic [FB_W-1:0] rem;
  logic [FB_W-1:0] dvs;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [FB_W:0]   trial;

  assign trial = {rem, quotient[PW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(PW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= FB_W'(trial - {1'b0, dvs});
        quotient <= {quotient[PW-2:0], 1'b1};
      end else begin
        rem      <= trial[FB_W-1:0];
        quotient <= {quotient[PW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[design/rwhp_dp.sv]
`default_nettype none
module rwhp_dp import rwhp_pkg::*; #(
  parameter int PW = POS_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic [7:0]       byte_value,
  input  wire cmd_t             cmd,
  output stat_t                 stat,
  output logic      [3:0]       o_status,
  output logic                  o_float,
  output logic                  o_rf64,
  output logic      [15:0]      o_ch,
  output logic      [31:0]      o_rate,
  output logic      [15:0]      o_bits,
  output logic      [PW-1:0]    o_offset,
  output logic      [PW-1:0]    o_size,
  output logic      [PW-1:0]    o_frames
);
  logic [15:0] max_ch;
  logic [31:0] min_rate, max_rate;
  logic [39:0] limit;

  logic [PW-1:0] pos, body_start, next_start, loc;
  logic [1:0]    kind;
  logic [31:0]   clen, coll, dlen;
  logic          rf64, pending, seen_fmt, seen_data;
  logic [3:0]    err;
  logic [15:0]   sh_tag, sh_ch, sh_bits, sh_sub;
  logic [31:0]   sh_rate, sh_dslow;
  logic [15:0]   f_tag, f_ch, f_bits, sub_fmt;
  logic [31:0]   f_rate;
  logic [63:0]   ext;

  logic [31:0]   coll_new;
  logic [PW-1:0] hd, bo, hdr_body, pos_inc;

  assign coll_new = {byte_value, coll[31:8]};
  assign hd       = pos - next_start;
  assign bo       = pos - body_start;
  assign hdr_body = next_start + PW'(8);
  assign pos_inc  = pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ch   <= MAX_CH_RST;
      min_rate <= MIN_RATE_RST;
      max_rate <= MAX_RATE_RST;
      limit    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_CH:   max_ch   <= cfg_data[15:0];
        REG_MIN_RATE: min_rate <= cfg_data[31:0];
        REG_MAX_RATE: max_rate <= cfg_data[31:0];
        REG_LIMIT:    limit    <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      pos        <= '0;
      body_start <= PW'(4);
      next_start <= PW'(12);
      kind       <= KIND_NONE;
      clen       <= '0;
      coll       <= '0;
      rf64       <= 1'b0;
      pending    <= 1'b0;
      seen_fmt   <= 1'b0;
      seen_data  <= 1'b0;
      err        <= ST_OK;
      sh_tag     <= '0;
      sh_ch      <= '0;
      sh_rate    <= '0;
      sh_bits    <= '0;
      sh_sub     <= '0;
      sh_dslow   <= '0;
      f_tag      <= '0;
      f_ch       <= '0;
      f_rate     <= '0;
      f_bits     <= '0;
      sub_fmt    <= '0;
      ext        <= '0;
      loc        <= '0;
      dlen       <= '0;
    end else if (cmd.byte_en) begin
      coll <= coll_new;
      pos  <= pos_inc;
      if (pos == PW'(3)) begin
        if (coll_new == MAGIC_RF64) rf64 <= 1'b1;
        else if (coll_new != MAGIC_RIFF && err == ST_OK) err <= ST_NOTRIFF;
      end else if (pos == PW'(11)) begin
        if (coll_new != MAGIC_WAVE && err == ST_OK) err <= ST_NOTWAVE;
      end
      if (pos >= PW'(12)) begin
        if (pos >= next_start) begin
          if (hd == PW'(3)) begin
            if (coll_new == ID_FMT) kind <= KIND_FMT;
            else if (coll_new == ID_DATA) kind <= KIND_DATA;
            else if (coll_new == ID_DS64 && rf64) kind <= KIND_DS64;
            else kind <= KIND_NONE;
          end else if (hd == PW'(7)) begin
            clen       <= coll_new;
            body_start <= hdr_body;
            next_start <= hdr_body + PW'(coll_new) + PW'(coll_new[0]);
            if (kind == KIND_DATA) begin
              loc       <= hdr_body;
              dlen      <= coll_new;
              seen_data <= 1'b1;
            end else if (kind == KIND_FMT) begin
              if (coll_new < 32'd16) begin
                if (err == ST_OK) err <= ST_FMTCORRUPT;
              end else begin
                pending <= 1'b1;
              end
            end
          end
        end else if (pos >= body_start && kind != KIND_NONE) begin
          if (kind == KIND_FMT && pending) begin
            if (bo == PW'(1)) sh_tag <= coll_new[31:16];
            else if (bo == PW'(3)) sh_ch <= coll_new[31:16];
            else if (bo == PW'(7)) sh_rate <= coll_new;
            else if (bo == PW'(15)) begin
              sh_bits <= coll_new[31:16];
              if (sh_tag != TAG_EXT) begin
                f_tag    <= sh_tag;
                f_ch     <= sh_ch;
                f_rate   <= sh_rate;
                f_bits   <= coll_new[31:16];
                seen_fmt <= 1'b1;
                pending  <= 1'b0;
              end else if (clen < 32'd40) begin
                if (err == ST_OK) err <= ST_EXTSMALL;
                pending <= 1'b0;
              end
            end else if (bo == PW'(25)) sh_sub <= coll_new[31:16];
            else if (bo == PW'(39)) begin
              f_tag    <= sh_tag;
              f_ch     <= sh_ch;
              f_rate   <= sh_rate;
              f_bits   <= sh_bits;
              seen_fmt <= 1'b1;
              pending  <= 1'b0;
              sub_fmt  <= sh_sub;
            end
          end else if (kind == KIND_DS64 && clen >= 32'd16) begin
            if (bo == PW'(11)) sh_dslow <= coll_new;
            else if (bo == PW'(15)) ext <= {coll_new, sh_dslow};
          end
        end
      end
    end
  end

  // end-of-file checks, captured once after the last byte
  logic [PW:0]    bs16;
  logic [15:0]    tag_eff;
  logic           flt;
  logic [63:0]    ds_sel;
  logic [PW-1:0]  avail, ds_clamp;
  logic [FB_W-1:0] fb;
  logic [3:0]     chk;

  assign bs16     = {1'b0, body_start} + (PW+1)'(16);
  assign tag_eff  = (f_tag == TAG_EXT) ? sub_fmt : f_tag;
  assign flt      = (tag_eff == TAG_FLOAT);
  assign ds_sel   = (rf64 && dlen == SIZE_ESC) ? ext : 64'(dlen);
  assign avail    = pos - loc;
  assign ds_clamp = (ds_sel > 64'(avail)) ? avail : PW'(ds_sel);
  assign fb       = FB_W'(f_ch * f_bits[6:3]);

  always_comb begin
    chk = ST_OK;
    if (pos < PW'(12)) chk = ST_SMALL;
    else if (err != ST_OK) chk = err;
    else if (pending) chk = ({1'b0, pos} < bs16) ? ST_FMTCORRUPT : ST_EXTSMALL;
    else if (!seen_fmt) chk = ST_NOFMT;
    else if (!seen_data) chk = ST_NODATA;
    else if (tag_eff != TAG_PCM && tag_eff != TAG_FLOAT) chk = ST_ENCODING;
    else if (flt && f_bits != 16'd32 && f_bits != 16'd64) chk = ST_FLOATBITS;
    else if (!flt && f_bits != 16'd8 && f_bits != 16'd16 && f_bits != 16'd24 &&
             f_bits != 16'd32) chk = ST_PCMBITS;
    else if (f_ch == 16'd0 || f_ch > max_ch) chk = ST_CHANNELS;
    else if (f_rate < min_rate || f_rate > max_rate) chk = ST_RATE;
    else if (fb == '0) chk = ST_HEADER;
  end

  logic [3:0]      fin_status;
  logic [PW-1:0]   fin_ds;
  logic [FB_W-1:0] fin_fb;
  logic            fin_flt;
  logic [PW-1:0]   quo;
  logic            div_done;
  logic [PW+15:0]  prod;

  always_ff @(posedge clk) begin
    if (cmd.check_en) begin
      fin_status <= chk;
      fin_ds     <= ds_clamp;
      fin_fb     <= fb;
      fin_flt    <= flt;
    end
    if (cmd.mul_en) prod <= quo * f_ch;
  end

  rwhp_div #(.PW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (fin_ds),
    .divisor  (fin_fb),
    .quotient (quo),
    .done     (div_done)
  );

  assign stat.fin_ok   = (fin_status == ST_OK);
  assign stat.div_done = div_done;

  logic [3:0] final_st;
  logic       good;
  always_comb begin
    if (fin_status != ST_OK) final_st = fin_status;
    else if (prod > (PW+16)'(limit)) final_st = ST_TOOLARGE;
    else final_st = ST_OK;
  end
  assign good = (final_st == ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_status <= final_st;
      o_float  <= good & fin_flt;
      o_rf64   <= good & rf64;
      o_ch     <= good ? f_ch : '0;
      o_rate   <= good ? f_rate : '0;
      o_bits   <= good ? f_bits : '0;
      o_offset <= good ? loc : '0;
      o_size   <= good ? fin_ds : '0;
      o_frames <= good ? quo : '0;
    end
  end
endmodule
`default_nettype wire

[design/rwhp_ctrl.sv]
`default_nettype none
module rwhp_ctrl import rwhp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  localparam logic [2:0] S_RUN   = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_RUN: begin
        in_ready    = 1'b1;
        cmd.byte_en = in_valid;
        if (in_valid && in_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check_en = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        if (stat.fin_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending one");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");
  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input taken right after the last byte");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");
endmodule
`default_nettype wire

[design/riff_wave_header_parser_unit.sv]
// bytes are taken at one per cycle while a file streams in
// a clean file's result goes through check, evaluate, restoring divide, multiply and load;
// a file with an error goes from check and evaluate straight to load
// no byte is taken from the last byte until the result is loaded into the output register
// synchronous reset clears the parse state and restores the register defaults
`default_nettype none
module riff_wave_header_parser_unit import rwhp_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  rwhp_in_if.sink               byte_in,
  rwhp_out_if.source            result_out,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;

  rwhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_in.valid),
    .in_last   (byte_in.last_byte),
    .in_ready  (byte_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rwhp_dp #(.PW(POS_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_value (byte_in.byte_value),
    .cmd        (cmd),
    .stat       (stat),
    .o_status   (result_out.status),
    .o_float    (result_out.is_float),
    .o_rf64     (result_out.is_rf64),
    .o_ch       (result_out.channel_count),
    .o_rate     (result_out.sample_rate),
    .o_bits     (result_out.bits_per_sample),
    .o_offset   (result_out.data_offset),
    .o_size     (result_out.data_size),
    .o_frames   (result_out.frame_count)
  );
endmodule
`default_nettype wire

[tb/rwhp_result_checker.sv]
module rwhp_result_checker
  import rwhp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rwhp_in_if               byte_in,
  rwhp_out_if              result_out,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding,
  output int               files_seen,
  output int               files_ok
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]                status;
    logic                      is_float;
    logic                      is_rf64;
    logic [15:0]               channel_count;
    logic [31:0]               sample_rate;
    logic [15:0]               bits_per_sample;
    logic [POS_WIDTH_DEF-1:0]  data_offset;
    logic [POS_WIDTH_DEF-1:0]  data_size;
    logic [POS_WIDTH_DEF-1:0]  frame_count;
  } wav_summary_t;

  wav_summary_t expected_summaries[$];

  // limits
  logic [15:0] max_ch;
  logic [31:0] rate_lo, rate_hi;
  logic [39:0] frame_limit;

  // parse state of the file in flight
  logic [63:0] pos, body_start, next_start, ext_size, data_loc;
  logic [1:0]  kind;
  logic [31:0] clen, coll, data_len, sh_rate, sh_ds_low, f_rate;
  logic [15:0] sh_tag, sh_ch, sh_bits, sh_sub, f_tag, f_ch, f_bits, sub_fmt;
  logic        rf64, fmt_pending, seen_fmt, seen_data;
  logic [3:0]  err;

  task automatic clear_file();
    pos = 0; body_start = 4; next_start = 12; kind = KIND_NONE;
    clen = 0; coll = 0; rf64 = 0; fmt_pending = 0; seen_fmt = 0; seen_data = 0;
    err = ST_OK; sh_tag = 0; sh_ch = 0; sh_rate = 0; sh_bits = 0; sh_sub = 0;
    sh_ds_low = 0; f_tag = 0; f_ch = 0; f_rate = 0; f_bits = 0; sub_fmt = 0;
    ext_size = 0; data_loc = 0; data_len = 0;
  endtask

  function automatic void latch_error(input logic [3:0] code);
    if (err == ST_OK) err = code;
  endfunction

  task automatic commit_fmt();
    f_tag = sh_tag; f_ch = sh_ch; f_rate = sh_rate; f_bits = sh_bits;
    seen_fmt = 1; fmt_pending = 0;
  endtask

  function automatic wav_summary_t summarize_file(input logic [63:0] size);
    wav_summary_t r;
    logic [15:0] tag;
    logic [63:0] ds, avail, fb, frames;
    logic        flt;
    r = '0;
    if (size < 12) begin
      r.status = ST_SMALL;
      return r;
    end
    if (fmt_pending) latch_error(size < body_start + 16 ? ST_FMTCORRUPT : ST_EXTSMALL);
    tag = (f_tag == TAG_EXT) ? sub_fmt : f_tag;
    flt = (tag == TAG_FLOAT);
    ds = data_len;
    if (rf64 && data_len == SIZE_ESC) ds = ext_size;
    avail = size - data_loc;
    if (ds > avail) ds = avail;
    fb = 64'(f_ch) * 64'(f_bits / 8);
    if (err != ST_OK) r.status = err;
    else if (!seen_fmt) r.status = ST_NOFMT;
    else if (!seen_data) r.status = ST_NODATA;
    else if (tag != TAG_PCM && tag != TAG_FLOAT) r.status = ST_ENCODING;
    else if (flt && f_bits != 32 && f_bits != 64) r.status = ST_FLOATBITS;
    else if (!flt && f_bits != 8 && f_bits != 16 && f_bits != 24 && f_bits != 32)
      r.status = ST_PCMBITS;
    else if (f_ch == 0 || f_ch > max_ch) r.status = ST_CHANNELS;
    else if (f_rate < rate_lo || f_rate > rate_hi) r.status = ST_RATE;
    else if (fb == 0) r.status = ST_HEADER;
    else begin
      frames = ds / fb;
      if (frames * 64'(f_ch) > 64'(frame_limit)) r.status = ST_TOOLARGE;
      else begin
        r.status = ST_OK;
        r.is_float = flt;
        r.is_rf64 = rf64;
        r.channel_count = f_ch;
        r.sample_rate = f_rate;
        r.bits_per_sample = f_bits;
        r.data_offset = data_loc[POS_WIDTH_DEF-1:0];
        r.data_size = ds[POS_WIDTH_DEF-1:0];
        r.frame_count = frames[POS_WIDTH_DEF-1:0];
      end
    end
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [63:0] p, d, o;
    p = pos;
    coll = {b, coll[31:8]};
    if (p == 3) begin
      if (coll == MAGIC_RF64) rf64 = 1;
      else if (coll != MAGIC_RIFF) latch_error(ST_NOTRIFF);
    end else if (p == 11 && coll != MAGIC_WAVE) begin
      latch_error(ST_NOTWAVE);
    end
    if (p >= 12) begin
      if (p >= next_start) begin
        d = p - next_start;
        if (d == 3) begin
          if (coll == ID_FMT) kind = KIND_FMT;
          else if (coll == ID_DATA) kind = KIND_DATA;
          else if (coll == ID_DS64 && rf64) kind = KIND_DS64;
          else kind = KIND_NONE;
        end else if (d == 7) begin
          clen = coll;
          body_start = next_start + 8;
          next_start = body_start + 64'(coll) + 64'(coll[0]);
          if (kind == KIND_DATA) begin
            data_loc = body_start; data_len = coll; seen_data = 1;
          end else if (kind == KIND_FMT) begin
            if (coll < 16) latch_error(ST_FMTCORRUPT);
            else fmt_pending = 1;
          end
        end
      end else if (p >= body_start && kind != KIND_NONE) begin
        o = p - body_start;
        if (kind == KIND_FMT && fmt_pending) begin
          case (o)
            1: sh_tag = coll[31:16];
            3: sh_ch = coll[31:16];
            7: sh_rate = coll;
            15: begin
              sh_bits = coll[31:16];
              if (sh_tag != TAG_EXT) commit_fmt();
              else if (clen < 40) begin
                latch_error(ST_EXTSMALL);
                fmt_pending = 0;
              end
            end
            25: sh_sub = coll[31:16];
            39: begin
              commit_fmt();
              sub_fmt = sh_sub;
            end
            default: ;
          endcase
        end else if (kind == KIND_DS64 && clen >= 16) begin
          if (o == 11) sh_ds_low = coll;
          else if (o == 15) ext_size = {coll, sh_ds_low};
        end
      end
    end
    pos = p + 1;
    if (last) begin
      expected_summaries.insert(expected_summaries.size(), summarize_file(p + 1));
      clear_file();
    end
  endtask

  always @(posedge clk) begin
    wav_summary_t got, want;
    if (rst) begin
      max_ch = MAX_CH_RST; rate_lo = MIN_RATE_RST; rate_hi = MAX_RATE_RST;
      frame_limit = LIMIT_RST;
      clear_file();
      expected_summaries.delete();
      mismatches = 0; files_seen = 0; files_ok = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_CH:   max_ch = cfg_data[15:0];
          REG_MIN_RATE: rate_lo = cfg_data[31:0];
          REG_MAX_RATE: rate_hi = cfg_data[31:0];
          REG_LIMIT:    frame_limit = cfg_data[39:0];
          default: ;
        endcase
      end
      if (byte_in.valid && byte_in.ready) parse_byte(byte_in.byte_value, byte_in.last_byte);
      if (result_out.valid && result_out.ready) begin
        got = '{result_out.status, result_out.is_float, result_out.is_rf64,
                result_out.channel_count, result_out.sample_rate,
                result_out.bits_per_sample, result_out.data_offset,
                result_out.data_size, result_out.frame_count};
        if (expected_summaries.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status=%0d", $time, got.status);
        end else begin
          want = expected_summaries.pop_front();
          files_seen++;
          if (want.status == ST_OK) files_ok++;
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch expected st=%0d flt=%0b rf=%0b ch=%0d rate=%0d bits=%0d",
                     $time, want.status, want.is_float, want.is_rf64, want.channel_count,
                     want.sample_rate, want.bits_per_sample);
            $display("%0t:   expected off=%0d size=%0d frames=%0d", $time,
                     want.data_offset, want.data_size, want.frame_count);
            $display("%0t:   actual   st=%0d flt=%0b rf=%0b ch=%0d rate=%0d bits=%0d",
                     $time, got.status, got.is_float, got.is_rf64, got.channel_count,
                     got.sample_rate, got.bits_per_sample);
            $display("%0t:   actual   off=%0d size=%0d frames=%0d", $time,
                     got.data_offset, got.data_size, got.frame_count);
          end
        end
      end
    end
    outstanding = expected_summaries.size();
  end

endmodule

[tb/riff_wave_header_parser_unit_test.sv]
module riff_wave_header_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rwhp_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN = POS_WIDTH_DEF + 10;
  localparam int N_DIRECTED = 23;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               mismatches, outstanding, files_seen, files_ok, idle_cycles;
  bit               long_hold;
  logic [7:0]       wav[$];

  rwhp_in_if byte_in();
  rwhp_out_if #(.PW(POS_WIDTH_DEF)) result_out();

  riff_wave_header_parser_unit uut (
    .clk(clk), .rst(rst), .byte_in(byte_in), .result_out(result_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rwhp_result_checker chk (
    .clk(clk), .rst(rst), .byte_in(byte_in), .result_out(result_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .files_seen(files_seen), .files_ok(files_ok)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk) begin
    if (rst || (byte_in.valid && byte_in.ready) || (result_out.valid && result_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    result_out.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        n = 400;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        result_out.ready <= 0;
        repeat (n) @(posedge clk);
      end
      result_out.ready <= 1;
      repeat ($urandom_range(0, 11)) @(posedge clk);
    end
  end

  task automatic put8(input logic [7:0] v);
    wav.insert(wav.size(), v);
  endtask

  task automatic put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) put8(v[8*i +: 8]);
  endtask

  task automatic fmt_chunk(input logic [31:0] fsize, input logic [15:0] tag, ch,
                           input logic [31:0] rate, input logic [15:0] bits, sub);
    logic [7:0] tmpl[40];
    foreach (tmpl[i]) tmpl[i] = 8'($urandom);
    {tmpl[1], tmpl[0]} = tag;
    {tmpl[3], tmpl[2]} = ch;
    {tmpl[7], tmpl[6], tmpl[5], tmpl[4]} = rate;
    {tmpl[15], tmpl[14]} = bits;
    {tmpl[25], tmpl[24]} = sub;
    put32(ID_FMT);
    put32(fsize);
    for (int i = 0; i < fsize; i++) put8(i < 40 ? tmpl[i] : 8'($urandom));
    if (fsize[0]) put8(8'($urandom));
  endtask

  task automatic ds64_chunk(input logic [31:0] dsize, input logic [63:0] big);
    put32(ID_DS64);
    put32(dsize);
    for (int i = 0; i < dsize; i++) put8((i >= 8 && i < 16) ? big[8*(i-8) +: 8] : 8'($urandom));
    if (dsize[0]) put8(8'($urandom));
  endtask

  // mode 0 is random, other modes are hand-picked corner cases
  task automatic build_file(input int mode);
    logic [31:0] head, form, rate, dsz, fsize, dssize;
    logic [15:0] tag, sub, ch, bits;
    logic [63:0] big;
    int          dlen, njunk, cut, r, jlen;
    bit          with_ds64, fmt_first, two_fmt, with_fmt, with_data, all_ones;
    head = MAGIC_RIFF; form = MAGIC_WAVE; tag = TAG_PCM; sub = TAG_PCM; ch = 2;
    rate = 44100; bits = 16; fsize = 16; dlen = 4; dsz = 4; big = 64'd12;
    dssize = 28; njunk = 0; cut = 0; with_ds64 = 0; fmt_first = 1; two_fmt = 0;
    with_fmt = 1; with_data = 1; all_ones = 0;
    if (mode == 0) begin
      r = $urandom_range(0, 3);
      if (r == 0) begin
        head = MAGIC_RF64;
        with_ds64 = $urandom_range(0, 4) != 0;
      end
      if ($urandom_range(0, 40) == 0) head = $urandom;
      if ($urandom_range(0, 40) == 0) form = $urandom;
      r = $urandom_range(0, 19);
      tag = r < 9 ? TAG_PCM : r < 15 ? TAG_FLOAT : r < 18 ? TAG_EXT : 16'($urandom);
      r = $urandom_range(0, 9);
      sub = r < 5 ? TAG_PCM : r < 9 ? TAG_FLOAT : 16'($urandom);
      r = $urandom_range(0, 19);
      ch = r == 0 ? 16'($urandom) : r == 1 ? 16'd0 : r == 2 ? 16'hFFFF : 16'($urandom_range(1, 8));
      r = $urandom_range(0, 9);
      rate = r < 4 ? 32'd44100 : r < 7 ? 32'd48000 : r < 8 ? 32'hFFFF_FFFF : 32'($urandom);
      r = $urandom_range(0, 11);
      case (r)
        0, 1: bits = 8;
        2, 3: bits = 16;
        4, 5: bits = 24;
        6, 7, 8: bits = 32;
        9: bits = 64;
        default: bits = 16'($urandom);
      endcase
      fsize = tag == TAG_EXT ? 40 : ($urandom_range(0, 3) == 0 ? 18 : 16);
      if ($urandom_range(0, 15) == 0) fsize = $urandom_range(0, 44);
      dlen = $urandom_range(0, 12);
      r = $urandom_range(0, 9);
      dsz = r < 5 ? 32'(dlen) : r < 7 ? 32'(dlen + $urandom_range(1, 300)) :
            r < 8 ? SIZE_ESC : r < 9 ? 32'($urandom_range(0, dlen)) : 32'($urandom);
      if (head == MAGIC_RF64 && $urandom_range(0, 1) == 0) dsz = SIZE_ESC;
      big = $urandom_range(0, 3) == 0 ? {32'($urandom), 32'($urandom)}
                                      : 64'($urandom_range(0, 200));
      dssize = $urandom_range(0, 5) == 0 ? 32'($urandom_range(0, 20)) : 32'd28;
      njunk = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
      fmt_first = $urandom_range(0, 7) != 0;
      two_fmt = $urandom_range(0, 9) == 0;
      with_fmt = $urandom_range(0, 24) != 0;
      with_data = $urandom_range(0, 24) != 0;
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, 90);
    end else begin
      case (mode)
        2: begin tag = TAG_FLOAT; bits = 32; ch = 1; rate = 48000; end
        3: begin tag = TAG_EXT; sub = TAG_FLOAT; bits = 64; fsize = 40; end
        4: begin head = MAGIC_RF64; with_ds64 = 1; dsz = SIZE_ESC; dlen = 20; big = 7; end
        5: head = 32'h4646_4953;
        6: form = 32'h4556_4158;
        7: fsize = 14;
        8: begin tag = TAG_EXT; fsize = 18; end
        9: with_fmt = 0;
        10: with_data = 0;
        11: cut = 30;
        12: begin tag = TAG_EXT; fsize = 40; cut = 50; end
        13: cut = 1;
        14: cut = 11;
        15: cut = 12;
        16: tag = 16'd2;
        17: begin tag = TAG_FLOAT; bits = 24; end
        18: bits = 12;
        19: ch = 0;
        20: begin with_ds64 = 1; dsz = SIZE_ESC; dlen = 9; end
        21: all_ones = 1;
        22: begin tag = TAG_FLOAT; bits = 64; rate = 32'hFFFF_FFFF; end
        23: begin head = MAGIC_RF64; with_ds64 = 1; dssize = 8; dsz = SIZE_ESC; end
        default: begin njunk = 1; dlen = 7; dsz = 7; end
      endcase
    end
    wav.delete();
    put32(head);
    put32($urandom);
    put32(form);
    if (with_ds64) ds64_chunk(dssize, big);
    repeat (njunk) begin
      jlen = $urandom_range(0, 9) | 1;
      put32({8'h6B, 8'h6E, 8'h75, 8'($urandom)});
      put32(jlen);
      repeat (jlen + 1) put8(8'($urandom));
    end
    if (with_fmt && fmt_first) fmt_chunk(fsize, tag, ch, rate, bits, sub);
    if (two_fmt) fmt_chunk(16, TAG_PCM, 16'($urandom_range(1, 4)), 22050, 8, sub);
    if (with_fmt && !fmt_first) fmt_chunk(fsize, tag, ch, rate, bits, sub);
    if (with_data) begin
      put32(ID_DATA);
      put32(dsz);
      repeat (dlen) put8(8'($urandom));
      if (dsz == dlen && dsz[0]) put8(8'($urandom));
    end
    if (all_ones) foreach (wav[i]) wav[i] = 8'hFF;
    if (cut > 0 && cut < wav.size()) wav = wav[0:cut-1];
  endtask

  task automatic send_file();
    int  n;
    bit  burst;
    burst = $urandom_range(0, 3) == 0;
    foreach (wav[i]) begin
      n = burst ? 0 : pick_gap();
      if (n > 0) begin
        byte_in.valid <= 0;
        repeat (n) @(posedge clk);
      end
      byte_in.valid <= 1;
      byte_in.byte_value <= wav[i];
      byte_in.last_byte <= (i == wav.size() - 1);
      do @(posedge clk); while (!byte_in.ready);
    end
    byte_in.valid <= 0;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] mc, input logic [31:0] lo, hi,
                            input logic [39:0] lim);
    put_reg(REG_MAX_CH, CFG_W'(mc));
    put_reg(REG_MIN_RATE, CFG_W'(lo));
    put_reg(REG_MAX_RATE, CFG_W'(hi));
    put_reg(REG_LIMIT, lim);
    cfg_we <= 0;
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_MAX_CH;
    cfg_data = '0;
    byte_in.valid = 0;
    byte_in.byte_value = 0;
    byte_in.last_byte = 0;
    long_hold = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_limits(MAX_CH_RST, MIN_RATE_RST, MAX_RATE_RST, LIMIT_RST);
    // the result side holds off once while the directed files are being sent
    long_hold = 1;
    for (int m = 1; m <= N_DIRECTED + 1; m++) begin
      build_file(m);
      send_file();
    end
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: set_limits(16'd1, 32'd1, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        1: set_limits(16'hFFFF, 32'd44100, 32'd48000, 40'd100);
        2: set_limits(16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'd1);
        3: set_limits(16'd8, 32'd8000, 32'd192000, 40'd2000000000);
        default: set_limits(MAX_CH_RST, MIN_RATE_RST, MAX_RATE_RST, LIMIT_RST);
      endcase
      build_file(0);
      send_file();
    end
    wait_drained();
    $display("parsed %0d wave files under five limit settings, %0d of them clean",
             files_seen, files_ok);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[riff_wave_header_parser_unit.f]
design/rwhp_pkg.sv
design/rwhp_if.sv
design/rwhp_div.sv
design/rwhp_dp.sv
design/rwhp_ctrl.sv
design/riff_wave_header_parser_unit.sv
tb/rwhp_result_checker.sv
tb/riff_wave_header_parser_unit_test.sv
